// ===== design/exptok_pkg.sv =====
// shared types, codes and character classes for the expression tokenizer
package exptok_pkg;

   // default line length limit
   localparam int MAX_LINE_DEF = 1024;

   // result queue depth (must leave room for two pushes)
   localparam int RSPQ_DEPTH = 4;

   // scanner modes
   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_NUM  = 3'd1,
      MODE_WORD = 3'd2,
      MODE_OP   = 3'd3,
      MODE_MAT  = 3'd4,
      MODE_SKIP = 3'd5
   } mode_type;

   // token kinds
   localparam logic [2:0] KIND_NUM   = 3'd0;
   localparam logic [2:0] KIND_WORD  = 3'd1;
   localparam logic [2:0] KIND_OP    = 3'd2;
   localparam logic [2:0] KIND_PAREN = 3'd3;
   localparam logic [2:0] KIND_MAT   = 3'd4;

   // operator codes
   localparam logic [3:0] OP_ADD    = 4'd0;
   localparam logic [3:0] OP_SUB    = 4'd1;
   localparam logic [3:0] OP_MUL    = 4'd2;
   localparam logic [3:0] OP_DIV    = 4'd3;
   localparam logic [3:0] OP_POW    = 4'd4;
   localparam logic [3:0] OP_MOD    = 4'd5;
   localparam logic [3:0] OP_ASN    = 4'd6;
   localparam logic [3:0] OP_ASNADD = 4'd7;
   localparam logic [3:0] OP_ASNSUB = 4'd8;
   localparam logic [3:0] OP_ASNMUL = 4'd9;
   localparam logic [3:0] OP_ASNDIV = 4'd10;
   localparam logic [3:0] OP_INC    = 4'd11;
   localparam logic [3:0] OP_DEC    = 4'd12;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_BADCHAR  = 2'd1;
   localparam logic [1:0] ERR_BADELEM  = 2'd2;
   localparam logic [1:0] ERR_UNTERM   = 2'd3;

   // characters
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_LBRK   = 8'h5B;
   localparam logic [7:0] CH_RBRK   = 8'h5D;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   // one result beat
   typedef struct packed {
      logic [2:0]  token_kind;
      logic [9:0]  start_pos;
      logic [10:0] end_pos;
      logic [3:0]  op_code;
      logic        paren_open;
      logic [1:0]  error_code;
      logic        last_of_line;
   } tok_result_type;

   // scanner state apart from the character position
   typedef struct packed {
      mode_type   mode;
      logic [9:0] tok_start;
      logic [1:0] pend_op;
   } scan_state_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_num_char(input logic [7:0] c);
      return is_digit(c) || (c == CH_DOT);
   endfunction

   function automatic logic is_alpha_char(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
             || (c == CH_UNDER);
   endfunction

   // build a result; an error result always closes the line
   function automatic tok_result_type make_res(input logic [2:0]  kind,
                                               input logic [9:0]  s,
                                               input logic [10:0] e,
                                               input logic [3:0]  op,
                                               input logic        paren,
                                               input logic [1:0]  err);
      tok_result_type r;
      r.token_kind   = kind;
      r.start_pos    = s;
      r.end_pos      = e;
      r.op_code      = op;
      r.paren_open   = paren;
      r.error_code   = err;
      r.last_of_line = (err != ERR_NONE);
      return r;
   endfunction

endpackage

// ===== design/exptok_if.sv =====
// valid/ready channel interfaces for characters and tokens
interface exptok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_line;

   modport source (output valid, output char_byte, output end_of_line, input ready);
   modport sink   (input valid, input char_byte, input end_of_line, output ready);
endinterface

interface exptok_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [9:0]  start_pos;
   logic [10:0] end_pos;
   logic [3:0]  op_code;
   logic        paren_open;
   logic [1:0]  error_code;
   logic        last_of_line;

   modport source (output valid, output token_kind, output start_pos, output end_pos,
                   output op_code, output paren_open, output error_code,
                   output last_of_line, input ready);
   modport sink   (input valid, input token_kind, input start_pos, input end_pos,
                   input op_code, input paren_open, input error_code,
                   input last_of_line, output ready);
endinterface

// ===== design/exptok_step.sv =====
// combinational lexer step: one character against the scanner state
module exptok_step import exptok_pkg::*; #(
   parameter int MAX_LINE = MAX_LINE_DEF,
   parameter int POS_W    = $clog2(MAX_LINE + 1)
) (
   input  scan_state_type  st_cur,
   input  logic [POS_W-1:0] pos_cur,
   input  logic [7:0]      char_byte,
   input  logic            end_of_line,
   output scan_state_type  st_nxt,
   output logic [POS_W-1:0] pos_nxt,
   output logic            res0_valid,
   output tok_result_type  res0,
   output logic            res1_valid,
   output tok_result_type  res1
);

   localparam int START_CAP = ((MAX_LINE - 1) < 1023) ? (MAX_LINE - 1) : 1023;
   localparam int END_CAP   = (MAX_LINE < 1024) ? MAX_LINE : 1024;
   localparam int EXT_W     = ((POS_W + 1) > 12) ? (POS_W + 1) : 12;

   logic [EXT_W-1:0] p_ext;
   logic [EXT_W-1:0] pe_ext;
   logic [9:0]       start_now;
   logic [10:0]      end_cur;
   logic [10:0]      end_now;

   // saturated positions of this character
   always_comb begin
      p_ext     = EXT_W'(pos_cur);
      pe_ext    = p_ext + EXT_W'(1);
      start_now = (p_ext > EXT_W'(START_CAP)) ? 10'(START_CAP) : p_ext[9:0];
      end_cur   = (p_ext > EXT_W'(END_CAP)) ? 11'(END_CAP) : p_ext[10:0];
      end_now   = (pe_ext > EXT_W'(END_CAP)) ? 11'(END_CAP) : pe_ext[10:0];
   end

   logic           done;
   logic           a_v;
   tok_result_type a_res;
   logic           bc_v;
   tok_result_type bc_res;
   mode_type       mode;
   logic [9:0]     ts;
   logic [1:0]     pend;
   logic [3:0]     pair_code;
   logic           paired;
   logic           mat_ok;

   always_comb begin
      done      = 1'b0;
      a_v       = 1'b0;
      a_res     = '0;
      bc_v      = 1'b0;
      bc_res    = '0;
      mode      = st_cur.mode;
      ts        = st_cur.tok_start;
      pend      = st_cur.pend_op;
      pair_code = OP_ADD;
      paired    = 1'b0;
      mat_ok    = (char_byte == CH_SPACE) || (char_byte == CH_TAB) ||
                  is_num_char(char_byte) || (char_byte == CH_SEMI) ||
                  (char_byte == CH_COMMA);

      // close or continue the token in progress
      unique case (st_cur.mode)
         MODE_OP: begin
            priority if ({2'b00, pend} == OP_ADD && char_byte == CH_PLUS) begin
               paired = 1'b1; pair_code = OP_INC;
            end else if ({2'b00, pend} == OP_ADD && char_byte == CH_EQ) begin
               paired = 1'b1; pair_code = OP_ASNADD;
            end else if ({2'b00, pend} == OP_SUB && char_byte == CH_MINUS) begin
               paired = 1'b1; pair_code = OP_DEC;
            end else if ({2'b00, pend} == OP_SUB && char_byte == CH_EQ) begin
               paired = 1'b1; pair_code = OP_ASNSUB;
            end else if ({2'b00, pend} == OP_MUL && char_byte == CH_EQ) begin
               paired = 1'b1; pair_code = OP_ASNMUL;
            end else if ({2'b00, pend} == OP_DIV && char_byte == CH_EQ) begin
               paired = 1'b1; pair_code = OP_ASNDIV;
            end else begin
               paired = 1'b0;
            end
            a_v = 1'b1;
            if (paired) begin
               a_res = make_res(KIND_OP, ts, end_now, pair_code, 1'b0, ERR_NONE);
               done  = 1'b1;
            end else begin
               a_res = make_res(KIND_OP, ts, end_cur, {2'b00, pend}, 1'b0, ERR_NONE);
            end
            pend = 2'b00;
            mode = MODE_IDLE;
         end
         MODE_NUM: begin
            if (is_num_char(char_byte)) begin
               done = 1'b1;
            end else begin
               a_v   = 1'b1;
               a_res = make_res(KIND_NUM, ts, end_cur, OP_ADD, 1'b0, ERR_NONE);
               mode  = MODE_IDLE;
            end
         end
         MODE_WORD: begin
            if (is_alpha_char(char_byte) || is_digit(char_byte)) begin
               done = 1'b1;
            end else begin
               a_v   = 1'b1;
               a_res = make_res(KIND_WORD, ts, end_cur, OP_ADD, 1'b0, ERR_NONE);
               mode  = MODE_IDLE;
            end
         end
         MODE_MAT: begin
            done = 1'b1;
            if (char_byte == CH_RBRK) begin
               a_v   = 1'b1;
               a_res = make_res(KIND_MAT, ts, end_now, OP_ADD, 1'b0, ERR_NONE);
               mode  = MODE_IDLE;
            end else if (!mat_ok) begin
               a_v   = 1'b1;
               a_res = make_res(KIND_MAT, ts, end_now, OP_ADD, 1'b0, ERR_BADELEM);
               mode  = MODE_SKIP;
            end
         end
         MODE_IDLE: begin
            done = 1'b0;
         end
         default: begin
            mode = MODE_SKIP;
            done = 1'b1;
         end
      endcase

      // start a new token with this character
      if (!done) begin
         priority if (char_byte == CH_SPACE) begin
            mode = mode;
         end else if (is_num_char(char_byte)) begin
            mode = MODE_NUM; ts = start_now;
         end else if (is_alpha_char(char_byte)) begin
            mode = MODE_WORD; ts = start_now;
         end else if (char_byte == CH_PLUS) begin
            mode = MODE_OP; ts = start_now; pend = OP_ADD[1:0];
         end else if (char_byte == CH_MINUS) begin
            mode = MODE_OP; ts = start_now; pend = OP_SUB[1:0];
         end else if (char_byte == CH_STAR) begin
            mode = MODE_OP; ts = start_now; pend = OP_MUL[1:0];
         end else if (char_byte == CH_SLASH) begin
            mode = MODE_OP; ts = start_now; pend = OP_DIV[1:0];
         end else if (char_byte == CH_BSLASH) begin
            bc_v   = 1'b1;
            bc_res = make_res(KIND_OP, start_now, end_now, OP_DIV, 1'b0, ERR_NONE);
         end else if (char_byte == CH_CARET) begin
            bc_v   = 1'b1;
            bc_res = make_res(KIND_OP, start_now, end_now, OP_POW, 1'b0, ERR_NONE);
         end else if (char_byte == CH_PCT) begin
            bc_v   = 1'b1;
            bc_res = make_res(KIND_OP, start_now, end_now, OP_MOD, 1'b0, ERR_NONE);
         end else if (char_byte == CH_EQ) begin
            bc_v   = 1'b1;
            bc_res = make_res(KIND_OP, start_now, end_now, OP_ASN, 1'b0, ERR_NONE);
         end else if (char_byte == CH_LPAR || char_byte == CH_RPAR) begin
            bc_v   = 1'b1;
            bc_res = make_res(KIND_PAREN, start_now, end_now, OP_ADD,
                              char_byte == CH_LPAR, ERR_NONE);
         end else if (char_byte == CH_LBRK) begin
            mode = MODE_MAT; ts = start_now;
         end else begin
            bc_v   = 1'b1;
            bc_res = make_res(KIND_NUM, start_now, end_now, OP_ADD, 1'b0, ERR_BADCHAR);
            mode   = MODE_SKIP;
         end
      end

      // flush an open token at end of line
      if (end_of_line) begin
         unique case (mode)
            MODE_NUM: begin
               bc_v   = 1'b1;
               bc_res = make_res(KIND_NUM, ts, end_now, OP_ADD, 1'b0, ERR_NONE);
            end
            MODE_WORD: begin
               bc_v   = 1'b1;
               bc_res = make_res(KIND_WORD, ts, end_now, OP_ADD, 1'b0, ERR_NONE);
            end
            MODE_OP: begin
               bc_v   = 1'b1;
               bc_res = make_res(KIND_OP, ts, end_now, {2'b00, pend}, 1'b0, ERR_NONE);
            end
            MODE_MAT: begin
               bc_v   = 1'b1;
               bc_res = make_res(KIND_MAT, ts, end_now, OP_ADD, 1'b0, ERR_UNTERM);
            end
            default: begin
               bc_v = bc_v;
            end
         endcase
      end
   end

   // order the results and mark the last one of the line
   always_comb begin
      res0_valid = a_v || bc_v;
      res1_valid = a_v && bc_v;
      res0       = a_v ? a_res : bc_res;
      res1       = bc_res;
      if (end_of_line) begin
         if (res1_valid) begin
            res1.last_of_line = 1'b1;
         end else begin
            res0.last_of_line = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      if (end_of_line) begin
         st_nxt.mode      = MODE_IDLE;
         st_nxt.tok_start = '0;
         st_nxt.pend_op   = '0;
         pos_nxt          = '0;
      end else begin
         st_nxt.mode      = mode;
         st_nxt.tok_start = ts;
         st_nxt.pend_op   = pend;
         pos_nxt          = (pos_cur < POS_W'(MAX_LINE)) ? pos_cur + POS_W'(1)
                                                         : POS_W'(MAX_LINE);
      end
   end

endmodule

// ===== design/exptok_rspq.sv =====
// small result queue taking up to two beats per cycle, one beat out while rsp_ch.ready is high
module exptok_rspq import exptok_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push0,
   input  tok_result_type       data0,
   input  logic                 push1,
   input  tok_result_type       data1,
   output logic                 room,
   exptok_rsp_if.source         rsp_ch
);

   localparam int PTR_W = $clog2(RSPQ_DEPTH);
   localparam int CNT_W = $clog2(RSPQ_DEPTH + 1);

   tok_result_type   slot_ff [RSPQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] count_left;
   logic             pop;

   // occupancy and pointer updates
   always_comb begin
      pop        = rsp_ch.valid && rsp_ch.ready;
      count_left = count_ff - CNT_W'(pop);
      room       = count_left <= CNT_W'(RSPQ_DEPTH - 2);
      count_in   = count_left + CNT_W'(push0) + CNT_W'(push1);
      wr_ptr_in  = wr_ptr_ff + PTR_W'(push0) + PTR_W'(push1);
      rd_ptr_in  = rd_ptr_ff + PTR_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // slot writes
   always_ff @(posedge clock) begin
      if (push0) begin
         slot_ff[wr_ptr_ff] <= data0;
      end
      if (push1) begin
         slot_ff[wr_ptr_ff + PTR_W'(1)] <= data1;
      end
   end

   // head beat
   always_comb begin
      rsp_ch.valid        = count_ff != '0;
      rsp_ch.token_kind   = slot_ff[rd_ptr_ff].token_kind;
      rsp_ch.start_pos    = slot_ff[rd_ptr_ff].start_pos;
      rsp_ch.end_pos      = slot_ff[rd_ptr_ff].end_pos;
      rsp_ch.op_code      = slot_ff[rd_ptr_ff].op_code;
      rsp_ch.paren_open   = slot_ff[rd_ptr_ff].paren_open;
      rsp_ch.error_code   = slot_ff[rd_ptr_ff].error_code;
      rsp_ch.last_of_line = slot_ff[rd_ptr_ff].last_of_line;
   end

endmodule

// ===== design/expression_tokenizer_core.sv =====
// expression tokenizer top level: input register, lexer step, result queue
//
//   channel   dir   beat
//   req_ch    in    char_byte, end_of_line
//   rsp_ch    out   token_kind, start_pos, end_pos, op_code, paren_open,
//                   error_code, last_of_line
//
// one character is taken per cycle while req_ch.ready is high; it yields zero, one or
// two result beats. the first result passes through the input register and then the
// queue before it appears; the single result port moves one beat per cycle while
// rsp_ch.ready is high, so characters that end two tokens need two output beats.
// synchronous reset clears the scanner state, the input register and the queue.
// a stalled rsp_ch fills the four-entry queue; req_ch.ready drops once it has
// less than room for two beats and the input register is occupied.
module expression_tokenizer_core import exptok_pkg::*; #(
   parameter int MAX_LINE = MAX_LINE_DEF
) (
   input  logic          clock,
   input  logic          reset,
   exptok_req_if.sink    req_ch,
   exptok_rsp_if.source  rsp_ch
);

   localparam int POS_W = $clog2(MAX_LINE + 1);

   logic             in_valid_ff;
   logic             in_valid_in;
   logic [7:0]       char_ff;
   logic             eol_ff;
   logic             consume;
   logic             q_room;
   scan_state_type   state_ff;
   scan_state_type   state_in;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic             r0_valid;
   logic             r1_valid;
   tok_result_type   r0;
   tok_result_type   r1;

   // input register handshake
   always_comb begin
      consume      = in_valid_ff && q_room;
      req_ch.ready = !in_valid_ff || consume;
      in_valid_in  = (req_ch.valid && req_ch.ready) || (in_valid_ff && !consume);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         char_ff <= req_ch.char_byte;
         eol_ff  <= req_ch.end_of_line;
      end
   end

   // lexer step
   exptok_step #(
      .MAX_LINE (MAX_LINE),
      .POS_W    (POS_W)
   ) u_step (
      .st_cur      (state_ff),
      .pos_cur     (pos_ff),
      .char_byte   (char_ff),
      .end_of_line (eol_ff),
      .st_nxt      (state_in),
      .pos_nxt     (pos_in),
      .res0_valid  (r0_valid),
      .res0        (r0),
      .res1_valid  (r1_valid),
      .res1        (r1)
   );

   // scanner state advances once per consumed character
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode      <= MODE_IDLE;
         state_ff.tok_start <= '0;
         state_ff.pend_op   <= '0;
         pos_ff             <= '0;
      end else if (consume) begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   // result queue
   exptok_rspq u_rspq (
      .clock  (clock),
      .reset  (reset),
      .push0  (consume && r0_valid),
      .data0  (r0),
      .push1  (consume && r1_valid),
      .data1  (r1),
      .room   (q_room),
      .rsp_ch (rsp_ch)
   );

`ifndef SYNTH
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !q_room |=> in_valid_ff && $stable(char_ff) && $stable(eol_ff))
      else $error("held character lost while queue full");

   a_eol_clears: assert property (@(posedge clock) disable iff (reset)
      consume && eol_ff |=> state_ff.mode == MODE_IDLE && pos_ff == '0)
      else $error("state not cleared after end of line");

   a_err_skips: assert property (@(posedge clock) disable iff (reset)
      consume && r0_valid && r0.error_code != ERR_NONE && !eol_ff
      |=> state_ff.mode == MODE_SKIP)
      else $error("error result without skipping rest of line");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      consume && r0_valid |=> rsp_ch.valid)
      else $error("pushed result not presented");
`endif

endmodule
